// File: sv/sads_pkg.sv
package sads_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ  = 2'd3
	} sads_req_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_NOENT = 2'd3
	} sads_sts_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_LD,
		S_WALK_RD,
		S_WALK_LD,
		S_RESP
	} sads_state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       stack_sel;
		logic [7:0] push_data;
	} sads_in_t;

	typedef struct packed {
		logic [7:0] out_data;
		logic       out_stack;
		logic [1:0] status;
		logic       last;
	} sads_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic pop_ld;
		logic walk_rd;
		logic walk_ld;
		logic walk_adv;
	} sads_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_rd;
		logic need_walk;
		logic walk_last;
	} sads_stat_t;

endpackage

// File: sv/sads_dp.sv
module sads_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sads_pkg::sads_in_t   req,
	input  sads_pkg::sads_cmd_t  cmd,
	output sads_pkg::sads_stat_t stat,
	output sads_pkg::sads_out_t  rsp
);
	import sads_pkg::*;

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_q;
	logic [CNT_W-1:0]  low_q;
	logic [CNT_W-1:0]  high_q;
	logic [CNT_W-1:0]  walk_q;
	logic              walk_stack_q;
	sads_out_t         rsp_q;

	logic [CNT_W:0]    total_w;
	logic [CNT_W-1:0]  total;
	logic              full;
	logic              sel_empty;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] pop_addr;
	logic [ADDR_W-1:0] walk_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              walk_upper;
	logic [CNT_W-1:0]  walk_off;
	logic [CNT_W-1:0]  walk_next;

	assign total_w   = {1'b0, low_q} + {1'b0, high_q};
	assign total     = total_w[CNT_W-1:0];
	assign full      = total_w >= (CNT_W + 1)'(DEPTH);
	assign sel_empty = req.stack_sel ? (high_q == '0) : (low_q == '0);

	assign wr_en   = cmd.accept && (req.req_type == REQ_PUSH) && !full;
	assign wr_addr = req.stack_sel ? ADDR_W'(CNT_W'(DEPTH - 1) - high_q) : low_q[ADDR_W-1:0];

	// The pop address is the top entry before the count moves.
	assign pop_addr = req.stack_sel ? ADDR_W'(CNT_W'(DEPTH) - high_q)
	                                : ADDR_W'(low_q - CNT_W'(1));

	// Walk order: the upward stack from entry 0, then the downward stack from entry DEPTH-1.
	assign walk_upper = walk_q >= low_q;
	assign walk_off   = walk_q - low_q;
	assign walk_addr  = walk_upper ? ADDR_W'(CNT_W'(DEPTH - 1) - walk_off)
	                               : walk_q[ADDR_W-1:0];
	assign rd_addr    = cmd.walk_rd ? walk_addr : pop_addr;
	assign walk_next  = walk_q + CNT_W'(1);

	assign stat.need_rd   = (req.req_type == REQ_POP) && !sel_empty;
	assign stat.need_walk = (req.req_type == REQ_READ) && (total != '0);
	assign stat.walk_last = walk_next == total;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.push_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.accept) begin
			case (req.req_type)
				REQ_PUSH: begin
					if (!full) begin
						if (req.stack_sel) high_q <= high_q + CNT_W'(1);
						else               low_q  <= low_q + CNT_W'(1);
					end
				end
				REQ_POP: begin
					if (!sel_empty) begin
						if (req.stack_sel) high_q <= high_q - CNT_W'(1);
						else               low_q  <= low_q - CNT_W'(1);
					end
				end
				REQ_CLEAR: begin
					if (req.stack_sel) high_q <= '0;
					else               low_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (cmd.accept) begin
			walk_q <= '0;
		end else if (cmd.walk_adv) begin
			walk_q <= walk_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_rd) begin
			walk_stack_q <= walk_upper;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q.out_data  <= '0;
			rsp_q.out_stack <= req.stack_sel;
			rsp_q.last      <= 1'b1;
			case (req.req_type)
				REQ_PUSH:  rsp_q.status <= full ? STS_FULL : STS_OK;
				REQ_POP:   rsp_q.status <= sel_empty ? STS_EMPTY : STS_OK;
				REQ_CLEAR: rsp_q.status <= STS_OK;
				REQ_READ: begin
					rsp_q.out_stack <= 1'b0;
					rsp_q.status    <= STS_NOENT;
				end
				default:   rsp_q.status <= STS_OK;
			endcase
		end else if (cmd.pop_ld) begin
			rsp_q.out_data <= rd_data_q;
		end else if (cmd.walk_ld) begin
			rsp_q.out_data  <= rd_data_q;
			rsp_q.out_stack <= walk_stack_q;
			rsp_q.status    <= STS_OK;
			rsp_q.last      <= stat.walk_last;
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_w <= (CNT_W + 1)'(DEPTH))
		else $error("stack counts exceed the store depth");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> (walk_q < total))
		else $error("read-out index beyond stored entries");

	a_walk_upper_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_rd && walk_upper) |-> (walk_off < high_q))
		else $error("read-out index beyond the downward stack");
`endif

endmodule

// File: sv/sads_ctrl.sv
module sads_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  sads_pkg::sads_stat_t stat,
	output sads_pkg::sads_cmd_t  cmd
);
	import sads_pkg::*;

	sads_state_t state_q;
	sads_state_t state_nxt;
	logic        walking_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			walking_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE) begin
				walking_q <= 1'b0;
			end else if (state_q == S_WALK_RD) begin
				walking_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (stat.need_rd)        state_nxt = S_POP_LD;
					else if (stat.need_walk) state_nxt = S_WALK_RD;
					else                     state_nxt = S_RESP;
				end
			end
			S_POP_LD:  state_nxt = S_RESP;
			S_WALK_RD: state_nxt = S_WALK_LD;
			S_WALK_LD: state_nxt = S_RESP;
			S_RESP: begin
				if (rsp_ready) begin
					if (walking_q && !stat.walk_last) state_nxt = S_WALK_RD;
					else                              state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		rsp_valid    = 1'b0;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_POP_LD:  cmd.pop_ld  = 1'b1;
			S_WALK_RD: cmd.walk_rd = 1'b1;
			S_WALK_LD: cmd.walk_ld = 1'b1;
			S_RESP: begin
				rsp_valid    = 1'b1;
				cmd.walk_adv = rsp_ready && walking_q && !stat.walk_last;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a result is pending");

	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_adv |=> (state_q == S_WALK_RD))
		else $error("read-out stopped before its last entry");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q != S_IDLE))
		else $error("accepted request produced no work");
`endif

endmodule

// File: sv/shared_array_double_stack_unit.sv
// Push, clear and refused requests: result valid in the cycle after the request transfer.
// Pop: the store is read at the transfer, and the registered read data is loaded into
// the result in S_POP_LD before it is offered in S_RESP. Read-out: per entry, the
// address and registered read (S_WALK_RD), the result load (S_WALK_LD) and the wait for
// each result transfer (S_RESP); a new request is taken only after the last result is transferred.
// Reset (arst_n low) empties both stacks at once and the unit takes requests right after.
module shared_array_double_stack_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sads_pkg::sads_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sads_pkg::sads_out_t rsp
);
	import sads_pkg::*;

	// The controller sequences one request at a time; the datapath holds the store,
	// both stack counts, the read-out index and the result register.
	sads_cmd_t  cmd;
	sads_stat_t stat;

	sads_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The request payload is only looked at in the cycle of its transfer, since the
	// controller accepts only in its idle state. The entry store is not cleared at
	// reset; only entries below the stack counts are ever read out.
	sads_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
